// File: hdl/rgb_box_blur_edge_normalized_macros.svh
// Assertion macros used by the checker file rbb_checker.sv.
`ifndef RGB_BOX_BLUR_EDGE_NORMALIZED_MACROS_SVH
`define RGB_BOX_BLUR_EDGE_NORMALIZED_MACROS_SVH

// Implication into the next cycle, ignored while reset is high.
`define RBB_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("rbb check failed");

// Implication into the next cycle, checked during reset too.
`define RBB_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("rbb check failed");

`endif

// File: hdl/rbb_pkg.sv
package rbb_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 7;
   localparam int MAX_HEIGHT     = 4096;
   localparam int RW             = 13;   // row counters, can hold MAX_HEIGHT

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 13;
   localparam logic [CSR_IW-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_BLUR_RADIUS  = 2'd2;

   localparam logic [10:0] WIDTH_RST  = 11'd640;
   localparam logic [12:0] HEIGHT_RST = 13'd480;
   localparam logic [2:0]  RADIUS_RST = 3'd3;

   typedef struct packed {
      logic load;       // latch the accepted word
      logic write;      // store the pixel, advance input position
      logic check;      // test readiness, latch window bounds
      logic issue;      // read one window entry
      logic div_start;
      logic div_step;
      logic emit;       // load result register, advance output position
   } ctl_cmd_type;

   typedef struct packed {
      logic proceed;
      logic emit_ok;
      logic sum_last;
      logic div_done;
      logic rsp_free;
   } ctl_sts_type;

endpackage

// File: hdl/rbb_ram.sv
module rbb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rbb_ctrl.sv
module rbb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output rbb_pkg::ctl_cmd_type cmd,
   input  rbb_pkg::ctl_sts_type sts
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRITE = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_TAIL  = 3'd4;
   localparam logic [2:0] S_DINIT = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = sts.proceed ? S_CHECK : S_IDLE;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.emit_ok ? S_SUM : S_IDLE;
         end
         S_SUM: begin
            cmd.issue = 1'b1;
            if (sts.sum_last) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: hdl/rbb_datapath.sv
module rbb_datapath #(
   parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = rbb_pkg::MAX_RADIUS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_cmd,
   input  logic [7:0]                  req_in_red,
   input  logic [7:0]                  req_in_green,
   input  logic [7:0]                  req_in_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_red,
   output logic [7:0]                  rsp_out_green,
   output logic [7:0]                  rsp_out_blue,
   output logic                        rsp_frame_end,
   input  logic                        csr_valid,
   input  logic [rbb_pkg::CSR_IW-1:0]  csr_index,
   input  logic [rbb_pkg::CSR_DW-1:0]  csr_data,
   input  rbb_pkg::ctl_cmd_type        cmd,
   output rbb_pkg::ctl_sts_type        sts
);

   localparam int RW    = rbb_pkg::RW;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = CW + 1;
   localparam int SLOTS = 2 * MAX_RADIUS + 2;
   localparam int SW    = $clog2(SLOTS);
   localparam int RADW  = $clog2(MAX_RADIUS + 1);
   localparam int NW    = RADW + 1;
   localparam int CNTW  = 2 * NW;
   localparam int SUMW  = CNTW + 8;
   localparam int STEPW = $clog2(SUMW);
   localparam int DEPTH = SLOTS * (2 ** CW);
   localparam int AW    = SW + CW;

   // configuration
   logic [10:0]      width_ff;
   logic [12:0]      height_ff;
   logic [2:0]       radius_ff;
   logic [WW-1:0]    w_eff;
   logic [RW-1:0]    h_eff;
   logic [RADW-1:0]  rad;
   logic             csr_restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rbb_pkg::WIDTH_RST;
         height_ff <= rbb_pkg::HEIGHT_RST;
         radius_ff <= rbb_pkg::RADIUS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            rbb_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data[10:0];
            rbb_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data;
            rbb_pkg::CSR_BLUR_RADIUS:  radius_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign csr_restart = csr_valid && ((csr_index == rbb_pkg::CSR_FRAME_WIDTH) ||
                                      (csr_index == rbb_pkg::CSR_FRAME_HEIGHT));

   always_comb begin
      if (width_ff == 11'd0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == 13'd0) begin
         h_eff = RW'(1);
      end else if (32'(height_ff) > rbb_pkg::MAX_HEIGHT) begin
         h_eff = RW'(rbb_pkg::MAX_HEIGHT);
      end else begin
         h_eff = RW'(height_ff);
      end
      if (32'(radius_ff) > MAX_RADIUS) begin
         rad = RADW'(MAX_RADIUS);
      end else begin
         rad = RADW'(radius_ff);
      end
   end

   // item and position counters
   logic            cmd_ff;
   logic [23:0]     pix_ff;
   logic [CW-1:0]   in_col_ff, out_col_ff;
   logic [RW-1:0]   in_row_ff, out_row_ff;
   logic [SW-1:0]   in_slot_ff, out_slot_ff;
   logic            wr_ok, in_done;
   logic            last_ff;

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
      return (32'(s) == SLOTS - 1) ? '0 : s + SW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         pix_ff <= {req_in_red, req_in_green, req_in_blue};
      end
   end

   assign wr_ok       = !cmd_ff && (in_row_ff < h_eff);
   assign sts.proceed = wr_ok || (cmd_ff && (in_row_ff >= h_eff));
   assign in_done     = (in_row_ff >= h_eff);

   always_ff @(posedge clock) begin
      if (reset || csr_restart || (cmd.emit && last_ff)) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
      end else begin
         if (cmd.write && wr_ok) begin
            if (WW'(in_col_ff) + WW'(1) >= w_eff) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + RW'(1);
               in_slot_ff <= slot_inc(in_slot_ff);
            end else begin
               in_col_ff <= in_col_ff + CW'(1);
            end
         end
         if (cmd.emit) begin
            if (WW'(out_col_ff) + WW'(1) >= w_eff) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + RW'(1);
               out_slot_ff <= slot_inc(out_slot_ff);
            end else begin
               out_col_ff <= out_col_ff + CW'(1);
            end
         end
      end
   end

   // readiness and window bounds
   logic [WW:0]     col_plus;
   logic [CW-1:0]   last_col;
   logic [WW-1:0]   lc1, need_col;
   logic            wrap_need;
   logic [RW+1:0]   need_row;
   logic            win_ready;
   logic            emit_ok;
   logic [RADW-1:0] up_r, dn_r, lf_c, rt_c;
   logic [RW-1:0]   rows_below;
   logic [CW-1:0]   cols_right;
   logic [NW-1:0]   nrows, ncols;
   logic [SW:0]     slot_sub;
   logic [SW-1:0]   start_slot;

   always_comb begin
      col_plus  = (WW+1)'(out_col_ff) + (WW+1)'(rad);
      last_col  = (col_plus < (WW+1)'(w_eff)) ? CW'(col_plus) : CW'(w_eff - WW'(1));
      lc1       = WW'(last_col) + WW'(1);
      wrap_need = (lc1 == w_eff);
      need_col  = wrap_need ? '0 : lc1;
      need_row  = (RW+2)'(out_row_ff) + (RW+2)'(rad) + (RW+2)'(wrap_need);
      win_ready = ((RW+2)'(in_row_ff) > need_row) ||
                  (((RW+2)'(in_row_ff) == need_row) && (WW'(in_col_ff) >= need_col));
      emit_ok   = (out_row_ff < h_eff) && (in_done || win_ready);

      up_r       = (out_row_ff >= RW'(rad)) ? rad : RADW'(out_row_ff);
      rows_below = h_eff - RW'(1) - out_row_ff;
      dn_r       = (rows_below >= RW'(rad)) ? rad : RADW'(rows_below);
      lf_c       = (WW'(out_col_ff) >= WW'(rad)) ? rad : RADW'(out_col_ff);
      cols_right = last_col - out_col_ff;
      rt_c       = RADW'(cols_right);
      nrows      = NW'(up_r) + NW'(dn_r) + NW'(1);
      ncols      = NW'(lf_c) + NW'(rt_c) + NW'(1);
      slot_sub   = (SW+1)'(out_slot_ff) - (SW+1)'(up_r);
      start_slot = slot_sub[SW] ? SW'(slot_sub + (SW+1)'(SLOTS)) : SW'(slot_sub);
   end

   assign sts.emit_ok = emit_ok;

   // window sweep
   logic [NW-1:0]   nrows_ff, ncols_ff, row_k_ff, col_k_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [CW-1:0]   clo_ff, cur_col_ff;
   logic [SW-1:0]   cur_slot_ff;
   logic            rd_vld_ff;
   logic [23:0]     rd_data;
   logic [SUMW-1:0] acc_ff [3];

   assign sts.sum_last = (row_k_ff == nrows_ff - NW'(1)) && (col_k_ff == ncols_ff - NW'(1));

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         nrows_ff    <= nrows;
         ncols_ff    <= ncols;
         cnt_ff      <= CNTW'(nrows) * CNTW'(ncols);
         clo_ff      <= out_col_ff - CW'(lf_c);
         cur_col_ff  <= out_col_ff - CW'(lf_c);
         cur_slot_ff <= start_slot;
         row_k_ff    <= '0;
         col_k_ff    <= '0;
         last_ff     <= (out_row_ff == h_eff - RW'(1)) &&
                        (WW'(out_col_ff) == w_eff - WW'(1));
      end else if (cmd.issue) begin
         if (col_k_ff == ncols_ff - NW'(1)) begin
            col_k_ff    <= '0;
            cur_col_ff  <= clo_ff;
            row_k_ff    <= row_k_ff + NW'(1);
            cur_slot_ff <= slot_inc(cur_slot_ff);
         end else begin
            col_k_ff   <= col_k_ff + NW'(1);
            cur_col_ff <= cur_col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (cmd.check) begin
            acc_ff[k] <= '0;
         end else if (rd_vld_ff) begin
            acc_ff[k] <= acc_ff[k] + SUMW'(rd_data[16-8*k +: 8]);
         end
      end
   end

   rbb_ram #(
      .WIDTH (24),
      .DEPTH (DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (cmd.write && wr_ok),
      .wr_addr (AW'({in_slot_ff, in_col_ff})),
      .wr_data (pix_ff),
      .rd_en   (cmd.issue),
      .rd_addr (AW'({cur_slot_ff, cur_col_ff})),
      .rd_data (rd_data)
   );

   // restoring divide, one quotient bit per cycle, three lanes
   logic [CNTW:0]    rem_ff [3];
   logic [SUMW-1:0]  quo_ff [3];
   logic [STEPW-1:0] step_ff;
   logic [CNTW:0]    trial [3];

   assign sts.div_done = (32'(step_ff) == SUMW - 1);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         trial[k] = {rem_ff[k][CNTW-1:0], quo_ff[k][SUMW-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         step_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            rem_ff[k] <= '0;
            quo_ff[k] <= acc_ff[k];
         end
      end else if (cmd.div_step) begin
         step_ff <= step_ff + STEPW'(1);
         for (int k = 0; k < 3; k++) begin
            if (trial[k] >= (CNTW+1)'(cnt_ff)) begin
               rem_ff[k] <= trial[k] - (CNTW+1)'(cnt_ff);
               quo_ff[k] <= {quo_ff[k][SUMW-2:0], 1'b1};
            end else begin
               rem_ff[k] <= trial[k];
               quo_ff[k] <= {quo_ff[k][SUMW-2:0], 1'b0};
            end
         end
      end
   end

   // result register
   logic       rsp_valid_ff;
   logic [7:0] red_ff, green_ff, blue_ff;
   logic       end_ff;

   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         red_ff   <= quo_ff[0][7:0];
         green_ff <= quo_ff[1][7:0];
         blue_ff  <= quo_ff[2][7:0];
         end_ff   <= last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;
   assign rsp_frame_end = end_ff;

endmodule

// File: hdl/rgb_box_blur_edge_normalized.sv
// A pixel or flush word that releases a result goes through the window sweep, which reads
// one row-store entry per cycle over N = window entries in frame (up to (2R+1)^2), then
// the divide over S = quotient bits (16 at MAX_RADIUS 7), then into the result register.
// A new word is accepted only after the previous word is done and any result it released is loaded.
// Reset: synchronous, active high; counters clear, registers return to 640x480, radius 3.
module rgb_box_blur_edge_normalized #(
   parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = rbb_pkg::MAX_RADIUS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [7:0]                  req_in_red,
   input  logic [7:0]                  req_in_green,
   input  logic [7:0]                  req_in_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_red,
   output logic [7:0]                  rsp_out_green,
   output logic [7:0]                  rsp_out_blue,
   output logic                        rsp_frame_end,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rbb_pkg::CSR_IW-1:0]  csr_index,
   input  logic [rbb_pkg::CSR_DW-1:0]  csr_data
);

   rbb_pkg::ctl_cmd_type cmd;
   rbb_pkg::ctl_sts_type sts;

   assign csr_ready = 1'b1;

   rbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rbb_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_cmd),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cmd           (cmd),
      .sts           (sts)
   );

endmodule

// File: hdl/rbb_checker.sv
`include "rgb_box_blur_edge_normalized_macros.svh"

module rbb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_red
);

   // reset leaves no word in the result register and the input open
   `RBB_ASSERT_NEXT_ALWAYS(a_reset_clean, clock, reset, !rsp_valid && req_ready)

   // one word in flight: input closes right after an accept
   `RBB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a result cannot appear in the cycle after an accept
   `RBB_ASSERT_NEXT(a_no_early_result, clock, reset,
      req_valid && req_ready && !rsp_valid, !rsp_valid)

   // hold a stalled result
   `RBB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_red))

endmodule

bind rgb_box_blur_edge_normalized rbb_checker u_rbb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_out_red (rsp_out_red)
);

// File: verif/rgb_box_blur_edge_normalized_test.sv
module rgb_box_blur_edge_normalized_test;

   localparam int SLOT_ROWS   = 2 * rbb_pkg::MAX_RADIUS_DEF + 2;
   localparam int SETTLE      = 300;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } blur_pixel_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_cmd = 1'b0;
   logic [7:0]                  req_in_red = '0;
   logic [7:0]                  req_in_green = '0;
   logic [7:0]                  req_in_blue = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [7:0]                  rsp_out_red;
   logic [7:0]                  rsp_out_green;
   logic [7:0]                  rsp_out_blue;
   logic                        rsp_frame_end;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [rbb_pkg::CSR_IW-1:0]  csr_index = '0;
   logic [rbb_pkg::CSR_DW-1:0]  csr_data = '0;

   // predictor state
   logic [23:0]  line_mem [0:SLOT_ROWS*rbb_pkg::MAX_WIDTH_DEF-1];
   int unsigned  col_in, row_in, col_out, row_out;
   int unsigned  cfg_width, cfg_height, cfg_radius;
   bit           frame_closed;

   blur_pixel_type blur_expected[$];
   int           failures = 0;
   int           words_sent = 0;
   bit           no_idle = 1'b0;
   longint       cycles = 0;

   rgb_box_blur_edge_normalized uut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void restart_position();
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
   endfunction

   function automatic bit blur_predict(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, output blur_pixel_type res);
      int unsigned w, h, rad, lastc, rlo, rhi, clo, chi, sr, sg, sb, cnt;
      longint unsigned got, need;
      logic [23:0] v;
      bit done;
      w = (cfg_width == 0) ? 1 : ((cfg_width > rbb_pkg::MAX_WIDTH_DEF) ?
                                  rbb_pkg::MAX_WIDTH_DEF : cfg_width);
      h = (cfg_height == 0) ? 1 : ((cfg_height > rbb_pkg::MAX_HEIGHT) ?
                                   rbb_pkg::MAX_HEIGHT : cfg_height);
      rad = (cfg_radius > rbb_pkg::MAX_RADIUS_DEF) ? rbb_pkg::MAX_RADIUS_DEF : cfg_radius;
      sr = 0; sg = 0; sb = 0;
      if (row_in > h) row_in = h;
      if (cmd == 1'b0) begin
         if (row_in >= h) return 0;
         line_mem[(row_in % SLOT_ROWS) * rbb_pkg::MAX_WIDTH_DEF +
                  col_in % rbb_pkg::MAX_WIDTH_DEF] = {r, g, b};
         col_in++;
         if (col_in >= w) begin
            col_in = 0;
            row_in++;
         end
      end else if (row_in < h) begin
         return 0;
      end
      done = (row_in >= h);
      if (row_out >= h) return 0;
      lastc = (col_out + rad < w) ? col_out + rad : w - 1;
      got = longint'(row_in) * w + col_in;
      need = longint'(row_out + rad) * w + lastc + 1;
      if (!done && got < need) return 0;
      rlo = (row_out >= rad) ? row_out - rad : 0;
      rhi = (row_out + rad < h) ? row_out + rad : h - 1;
      clo = (col_out >= rad) ? col_out - rad : 0;
      chi = lastc;
      for (int unsigned i = rlo; i <= rhi; i++)
         for (int unsigned j = clo; j <= chi; j++) begin
            v = line_mem[(i % SLOT_ROWS) * rbb_pkg::MAX_WIDTH_DEF +
                         j % rbb_pkg::MAX_WIDTH_DEF];
            sr += v[23:16];
            sg += v[15:8];
            sb += v[7:0];
         end
      cnt = (rhi - rlo + 1) * (chi - clo + 1);
      res.red = 8'(sr / cnt);
      res.green = 8'(sg / cnt);
      res.blue = 8'(sb / cnt);
      res.frame_end = (row_out == h - 1) && (col_out == w - 1);
      col_out++;
      if (col_out >= w) begin
         col_out = 0;
         row_out++;
      end
      if (res.frame_end) begin
         restart_position();
         frame_closed = 1'b1;
      end
      return 1;
   endfunction

   task automatic send_word(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
      int gap;
      blur_pixel_type res;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd = cmd;
      req_in_red = r;
      req_in_green = g;
      req_in_blue = b;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (blur_predict(cmd, r, g, b, res)) blur_expected.push_back(res);
   endtask

   task automatic send_pixel();
      send_word(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (blur_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rbb_pkg::CSR_IW-1:0] idx,
                            input logic [rbb_pkg::CSR_DW-1:0] data);
      drain();
      @(negedge clock);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rbb_pkg::CSR_FRAME_WIDTH: begin
            cfg_width = data[10:0];
            restart_position();
         end
         rbb_pkg::CSR_FRAME_HEIGHT: begin
            cfg_height = data[12:0];
            restart_position();
         end
         rbb_pkg::CSR_BLUR_RADIUS: cfg_radius = data[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_frame(input int w, input int h, input int r);
      write_reg(rbb_pkg::CSR_FRAME_WIDTH, rbb_pkg::CSR_DW'(w));
      write_reg(rbb_pkg::CSR_FRAME_HEIGHT, rbb_pkg::CSR_DW'(h));
      write_reg(rbb_pkg::CSR_BLUR_RADIUS, rbb_pkg::CSR_DW'(r));
   endtask

   // result side: random stall per word, then compare with the oldest expectation
   always begin
      int stall;
      blur_pixel_type e;
      wait (!reset);
      stall = no_idle ? 0 : $urandom_range(0, 13);
      repeat (stall) @(negedge clock);
      rsp_ready = 1'b1;
      do @(posedge clock); while (!rsp_valid);
      if (blur_expected.size() == 0) begin
         $error("result word with nothing expected");
         failures++;
      end else begin
         e = blur_expected.pop_front();
         if (rsp_out_red !== e.red) begin
            $error("out_red expected %0d actual %0d", e.red, rsp_out_red);
            failures++;
         end
         if (rsp_out_green !== e.green) begin
            $error("out_green expected %0d actual %0d", e.green, rsp_out_green);
            failures++;
         end
         if (rsp_out_blue !== e.blue) begin
            $error("out_blue expected %0d actual %0d", e.blue, rsp_out_blue);
            failures++;
         end
         if (rsp_frame_end !== e.frame_end) begin
            $error("frame_end expected %0d actual %0d", e.frame_end, rsp_frame_end);
            failures++;
         end
      end
      @(negedge clock);
      rsp_ready = 1'b0;
   end

   task automatic test_reset_defaults();
      // 640x480 radius 3: nothing is ready yet, and flush mid-frame gives nothing
      repeat (3) send_pixel();
      send_word(1'b1, 8'hFF, 8'hFF, 8'hFF);
   endtask

   task automatic test_small_frame();
      logic [7:0] corner [4] = '{8'h00, 8'hFF, 8'hAA, 8'h55};
      set_frame(4, 3, 1);
      for (int i = 0; i < 12; i++)
         send_word(1'b0, corner[i % 4], corner[(i + 1) % 4], corner[(i + 2) % 4]);
      // frame complete: pixel ignored, flushes drain the remaining results, the last row among them
      send_word(1'b0, 8'hFF, 8'h00, 8'hFF);
      frame_closed = 1'b0;
      while (!frame_closed) send_word(1'b1, 8'h00, 8'h00, 8'h00);
      send_word(1'b1, 8'h00, 8'h00, 8'h00);
   endtask

   task automatic test_extremes();
      // zero size reads as 1x1, every pixel closes a frame
      set_frame(0, 0, 0);
      send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
      send_word(1'b0, 8'h00, 8'h00, 8'h00);
      // oversize width saturates, nothing becomes ready
      set_frame(13'h1FFF, 13'h1FFF, 7);
      repeat (4) send_pixel();
      // single column, tall frame, no blur
      set_frame(1, 8191, 0);
      repeat (4) send_pixel();
      // back to a small frame before the random frames
      set_frame(5, 4, 2);
   endtask

   task automatic test_random_frames();
      int w, h, r, npix, cut;
      while (words_sent < 1150) begin
         if ($urandom_range(0, 9) == 0) w = $urandom_range(13, 40);
         else w = $urandom_range(1, 12);
         h = $urandom_range(1, 10);
         r = $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0) write_reg(rbb_pkg::CSR_BLUR_RADIUS, rbb_pkg::CSR_DW'(r));
         else set_frame(w, h, r);
         w = (cfg_width == 0) ? 1 : cfg_width;
         h = (cfg_height == 0) ? 1 : cfg_height;
         npix = w * h;
         cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npix - 1) : npix;
         no_idle = ($urandom_range(0, 4) == 0);
         frame_closed = 1'b0;
         for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 19) == 0) send_word(1'b1, 8'($urandom), 8'($urandom),
                                                      8'($urandom));
            if (i == npix / 2 && $urandom_range(0, 7) == 0) begin
               @(negedge clock);
               req_valid = 1'b0;
               while (blur_expected.size() != 0) @(posedge clock);
            end
            send_pixel();
         end
         if (cut == npix) begin
            if ($urandom_range(0, 4) == 0) send_pixel();
            while (!frame_closed) send_word(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      foreach (line_mem[i]) line_mem[i] = '0;
      restart_position();
      cfg_width = rbb_pkg::WIDTH_RST;
      cfg_height = rbb_pkg::HEIGHT_RST;
      cfg_radius = rbb_pkg::RADIUS_RST;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_small_frame();
      test_extremes();
      test_random_frames();
      drain();
      if (failures == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// File: rgb_box_blur_edge_normalized.f
+incdir+hdl
hdl/rbb_pkg.sv
hdl/rbb_ram.sv
hdl/rbb_ctrl.sv
hdl/rbb_datapath.sv
hdl/rgb_box_blur_edge_normalized.sv
hdl/rbb_checker.sv
verif/rgb_box_blur_edge_normalized_test.sv
